// ===== rtl/core/jsu_pkg.sv =====
// jsu_pkg: shared types and codes of the json string unescape / utf-8 check block
// used by jsu_decode and json_string_unescape_utf8_check_top; no dependencies
package jsu_pkg;

   // decoder phase
   typedef enum logic [3:0] {
      PH_BODY     = 4'd0,
      PH_ESCAPE   = 4'd1,
      PH_HEX      = 4'd2,
      PH_OCTAL    = 4'd3,
      PH_UNICODE  = 4'd4,
      PH_LOW_BSL  = 4'd5,
      PH_LOW_U    = 4'd6,
      PH_LOW_DIG  = 4'd7,
      PH_UTF8     = 4'd8
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [4:0] ERR_NONE          = 5'd0;
   localparam logic [4:0] ERR_NEWLINE       = 5'd1;
   localparam logic [4:0] ERR_CONTROL       = 5'd2;
   localparam logic [4:0] ERR_BAD_ESCAPE    = 5'd3;
   localparam logic [4:0] ERR_STRICT        = 5'd4;
   localparam logic [4:0] ERR_HEX_DIGIT     = 5'd5;
   localparam logic [4:0] ERR_OCT_DIGIT     = 5'd6;
   localparam logic [4:0] ERR_OCT_RANGE     = 5'd7;
   localparam logic [4:0] ERR_UNI_DIGIT     = 5'd8;
   localparam logic [4:0] ERR_NO_LOW        = 5'd9;
   localparam logic [4:0] ERR_BAD_LOW       = 5'd10;
   localparam logic [4:0] ERR_LONE_LOW      = 5'd11;
   localparam logic [4:0] ERR_UTF8_LEAD     = 5'd12;
   localparam logic [4:0] ERR_UTF8_SHORT    = 5'd13;
   localparam logic [4:0] ERR_UTF8_OVERLONG = 5'd14;
   localparam logic [4:0] ERR_UTF8_SURR     = 5'd15;
   localparam logic [4:0] ERR_UTF8_RANGE    = 5'd16;
   localparam logic [4:0] ERR_UNCLOSED      = 5'd17;

   // results per input byte and result queue depth
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned QUEUE_DEPTH = 8;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  digits_left;
      logic [20:0] code_accum;
      logic [15:0] high_surrogate;
      logic [1:0]  utf8_extra;
   } state_type;

   localparam state_type STATE_RESET = '{PH_BODY, 3'd0, 21'd0, 16'd0, 2'd0};

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [4:0] error_code;
   } result_type;

   // results caused by one input byte, entry 0 first
   typedef struct packed {
      logic [2:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } group_type;

endpackage

// ===== rtl/core/jsu_decode.sv =====
// jsu_decode: one step of the string body decoder, state and byte in, results out
// depends on jsu_pkg
module jsu_decode import jsu_pkg::*; (
   input  state_type  cur,
   input  logic       strict_json,
   input  logic [7:0] data_byte,
   input  logic       end_of_stream,
   output state_type  nxt,
   output group_type  grp
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_B     = "b";
   localparam logic [7:0] CH_F     = "f";
   localparam logic [7:0] CH_N     = "n";
   localparam logic [7:0] CH_R     = "r";
   localparam logic [7:0] CH_T     = "t";
   localparam logic [7:0] CH_X     = "x";
   localparam logic [7:0] CH_U     = "u";
   localparam logic [7:0] CH_0     = "0";
   localparam logic [7:0] CH_7     = "7";

   function automatic result_type mk(logic [7:0] b, logic [1:0] k, logic [4:0] e);
      result_type r;
      r.out_byte   = b;
      r.kind       = k;
      r.error_code = e;
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") r = {1'b1, c[3:0]};
      else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   // utf-8 encoding of a code point, up to four bytes
   function automatic group_type emit_cp(logic [20:0] cp);
      group_type g;
      g = '0;
      if (cp < 21'h80) begin
         g.count  = 3'd1;
         g.res[0] = mk(cp[7:0], KIND_DATA, ERR_NONE);
      end else if (cp < 21'h800) begin
         g.count  = 3'd2;
         g.res[0] = mk({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
         g.res[1] = mk({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else if (cp < 21'h10000) begin
         g.count  = 3'd3;
         g.res[0] = mk({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
         g.res[1] = mk({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         g.res[2] = mk({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else begin
         g.count  = 3'd4;
         g.res[0] = mk({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
         g.res[1] = mk({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
         g.res[2] = mk({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         g.res[3] = mk({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end
      return g;
   endfunction

   logic [4:0]  hv;
   logic [7:0]  acc8;
   logic [8:0]  acc9;
   logic [15:0] acc16;
   logic [20:0] acc21;
   logic [20:0] minv;
   logic [20:0] pair_cp;
   logic [2:0]  dl_dec;
   logic [1:0]  ux_dec;
   logic [2:0]  oct_digit;

   always_comb begin
      hv        = hex_val(data_byte);
      acc8      = {cur.code_accum[3:0], hv[3:0]};
      oct_digit = data_byte[2:0];
      acc9      = {cur.code_accum[5:0], oct_digit};
      acc16     = {cur.code_accum[11:0], hv[3:0]};
      acc21     = {cur.code_accum[14:0], data_byte[5:0]};
      dl_dec    = cur.digits_left - 3'd1;
      ux_dec    = cur.utf8_extra - 2'd1;
      pair_cp   = 21'h10000 + {1'b0, cur.high_surrogate[9:0], acc16[9:0]};
      minv      = (cur.digits_left == 3'd1) ? 21'h80 :
                  (cur.digits_left == 3'd2) ? 21'h800 : 21'h10000;

      nxt = cur;
      grp = '0;

      if (end_of_stream) begin
         grp.count  = 3'd1;
         grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UNCLOSED);
         nxt        = STATE_RESET;
      end else begin
         unique case (cur.phase)
            PH_ESCAPE: begin
               nxt.phase = PH_BODY;
               grp.count = 3'd1;
               case (data_byte)
                  CH_NL: begin
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_NEWLINE);
                     nxt        = STATE_RESET;
                  end
                  CH_QUOTE, CH_BSL, CH_SLASH: grp.res[0] = mk(data_byte, KIND_DATA, ERR_NONE);
                  CH_B: grp.res[0] = mk(8'h08, KIND_DATA, ERR_NONE);
                  CH_F: grp.res[0] = mk(8'h0c, KIND_DATA, ERR_NONE);
                  CH_N: grp.res[0] = mk(8'h0a, KIND_DATA, ERR_NONE);
                  CH_R: grp.res[0] = mk(8'h0d, KIND_DATA, ERR_NONE);
                  CH_T: grp.res[0] = mk(8'h09, KIND_DATA, ERR_NONE);
                  CH_X: begin
                     if (strict_json) begin
                        grp.res[0] = mk(8'd0, KIND_ERROR, ERR_STRICT);
                        nxt        = STATE_RESET;
                     end else begin
                        grp.count       = 3'd0;
                        nxt.phase       = PH_HEX;
                        nxt.digits_left = 3'd2;
                        nxt.code_accum  = 21'd0;
                     end
                  end
                  CH_U: begin
                     grp.count       = 3'd0;
                     nxt.phase       = PH_UNICODE;
                     nxt.digits_left = 3'd4;
                     nxt.code_accum  = 21'd0;
                  end
                  default: begin
                     if (data_byte >= CH_0 && data_byte <= CH_7) begin
                        if (strict_json) begin
                           grp.res[0] = mk(8'd0, KIND_ERROR, ERR_STRICT);
                           nxt        = STATE_RESET;
                        end else begin
                           grp.count       = 3'd0;
                           nxt.phase       = PH_OCTAL;
                           nxt.digits_left = 3'd2;
                           nxt.code_accum  = {18'd0, oct_digit};
                        end
                     end else begin
                        grp.res[0] = mk(8'd0, KIND_ERROR, ERR_BAD_ESCAPE);
                        nxt        = STATE_RESET;
                     end
                  end
               endcase
            end
            PH_HEX: begin
               if (!hv[4]) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_HEX_DIGIT);
                  nxt        = STATE_RESET;
               end else if (dl_dec == 3'd0) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(acc8, KIND_DATA, ERR_NONE);
                  nxt        = STATE_RESET;
               end else begin
                  nxt.code_accum  = {13'd0, acc8};
                  nxt.digits_left = dl_dec;
               end
            end
            PH_OCTAL: begin
               if (data_byte < CH_0 || data_byte > CH_7) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_OCT_DIGIT);
                  nxt        = STATE_RESET;
               end else if (dl_dec == 3'd0) begin
                  grp.count  = 3'd1;
                  nxt        = STATE_RESET;
                  if (acc9[8]) grp.res[0] = mk(8'd0, KIND_ERROR, ERR_OCT_RANGE);
                  else         grp.res[0] = mk(acc9[7:0], KIND_DATA, ERR_NONE);
               end else begin
                  nxt.code_accum  = {12'd0, acc9};
                  nxt.digits_left = dl_dec;
               end
            end
            PH_UNICODE, PH_LOW_DIG: begin
               if (!hv[4]) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UNI_DIGIT);
                  nxt        = STATE_RESET;
               end else if (dl_dec != 3'd0) begin
                  nxt.code_accum  = {5'd0, acc16};
                  nxt.digits_left = dl_dec;
               end else if (cur.phase == PH_UNICODE) begin
                  if (acc16[15:10] == 6'b110110) begin
                     // high surrogate, wait for the low half
                     nxt.high_surrogate = acc16;
                     nxt.code_accum     = {5'd0, acc16};
                     nxt.digits_left    = 3'd0;
                     nxt.phase          = PH_LOW_BSL;
                  end else if (acc16[15:10] == 6'b110111) begin
                     grp.count  = 3'd1;
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_LONE_LOW);
                     nxt        = STATE_RESET;
                  end else begin
                     grp = emit_cp({5'd0, acc16});
                     nxt = STATE_RESET;
                  end
               end else begin
                  nxt = STATE_RESET;
                  if (acc16[15:10] != 6'b110111) begin
                     grp.count  = 3'd1;
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_BAD_LOW);
                  end else begin
                     grp = emit_cp(pair_cp);
                  end
               end
            end
            PH_LOW_BSL: begin
               if (data_byte != CH_BSL) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_NO_LOW);
                  nxt        = STATE_RESET;
               end else begin
                  nxt.phase = PH_LOW_U;
               end
            end
            PH_LOW_U: begin
               if (data_byte != CH_U) begin
                  grp.count  = 3'd1;
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_NO_LOW);
                  nxt        = STATE_RESET;
               end else begin
                  nxt.phase       = PH_LOW_DIG;
                  nxt.digits_left = 3'd4;
                  nxt.code_accum  = 21'd0;
               end
            end
            PH_UTF8: begin
               grp.count = 3'd1;
               if (data_byte[7:6] != 2'b10) begin
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UTF8_SHORT);
                  nxt        = STATE_RESET;
               end else if (ux_dec != 2'd0) begin
                  grp.res[0]     = mk(data_byte, KIND_DATA, ERR_NONE);
                  nxt.code_accum = acc21;
                  nxt.utf8_extra = ux_dec;
               end else begin
                  nxt = STATE_RESET;
                  if (acc21 < minv)
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UTF8_OVERLONG);
                  else if (acc21[20:11] == 10'b0000011011)
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UTF8_SURR);
                  else if (acc21 > 21'h10ffff)
                     grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UTF8_RANGE);
                  else
                     grp.res[0] = mk(data_byte, KIND_DATA, ERR_NONE);
               end
            end
            default: begin
               nxt.phase = PH_BODY;
               grp.count = 3'd1;
               if (data_byte == CH_QUOTE) begin
                  grp.res[0] = mk(8'd0, KIND_CLOSE, ERR_NONE);
                  nxt        = STATE_RESET;
               end else if (data_byte == CH_BSL) begin
                  grp.count = 3'd0;
                  nxt.phase = PH_ESCAPE;
               end else if (data_byte == CH_NL) begin
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_NEWLINE);
                  nxt        = STATE_RESET;
               end else if (data_byte < 8'h20) begin
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_CONTROL);
                  nxt        = STATE_RESET;
               end else if (!data_byte[7]) begin
                  grp.res[0] = mk(data_byte, KIND_DATA, ERR_NONE);
               end else if (data_byte[7:5] == 3'b110) begin
                  grp.res[0]      = mk(data_byte, KIND_DATA, ERR_NONE);
                  nxt.digits_left = 3'd1;
                  nxt.utf8_extra  = 2'd1;
                  nxt.code_accum  = {16'd0, data_byte[4:0]};
                  nxt.phase       = PH_UTF8;
               end else if (data_byte[7:4] == 4'b1110) begin
                  grp.res[0]      = mk(data_byte, KIND_DATA, ERR_NONE);
                  nxt.digits_left = 3'd2;
                  nxt.utf8_extra  = 2'd2;
                  nxt.code_accum  = {17'd0, data_byte[3:0]};
                  nxt.phase       = PH_UTF8;
               end else if (data_byte[7:3] == 5'b11110) begin
                  grp.res[0]      = mk(data_byte, KIND_DATA, ERR_NONE);
                  nxt.digits_left = 3'd3;
                  nxt.utf8_extra  = 2'd3;
                  nxt.code_accum  = {18'd0, data_byte[2:0]};
                  nxt.phase       = PH_UTF8;
               end else begin
                  grp.res[0] = mk(8'd0, KIND_ERROR, ERR_UTF8_LEAD);
                  nxt        = STATE_RESET;
               end
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/json_string_unescape_utf8_check_top.sv =====
// json_string_unescape_utf8_check_top: json string body unescape with utf-8 checking
// depends on jsu_pkg and jsu_decode
//
// usage
//   req channel: one byte of the string body per transaction (after the opening
//     quote); req_tlast high marks end of input, the data byte is then ignored
//   rsp channel: decoded bytes (kind 0), a close marker (kind 1) or an error
//     (kind 2 with a code); rsp_tlast marks the last result of one input byte
//   csr channel: writes strict_json, always ready; write only while idle
//   each input byte yields 0 to 4 results; data bytes are tentative, an error
//   means the consumer drops the whole string
// timing
//   results are registered in the result queue and shown on rsp in order
//   one input byte per cycle is taken while the 8-entry result queue has room
//   for a full group of 4; one byte per cycle is sustained only while bytes yield at most
//   one result on average and the receiver takes one per cycle (single read port)
// reset
//   synchronous; decoder returns to the plain string body, queue empties,
//   strict_json goes to 1
// stall
//   when rsp_tready is low results wait in the queue and req_tready drops once
//   fewer than 4 entries are free; nothing is lost or repeated
module json_string_unescape_utf8_check_top import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_stream
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [12:8] error_code, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last result of an input byte
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // strict_json
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = PTR_W + 1;

   logic        strict_ff, strict_in;
   state_type   state_ff, state_in;
   state_type   dec_next;
   group_type   dec_grp;

   // result queue
   result_type            queue_mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] queue_last_ff;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic req_xfer;
   logic rsp_xfer;
   logic [2:0] push_count;

   jsu_decode u_decode (
      .cur           (state_ff),
      .strict_json   (strict_ff),
      .data_byte     (req_tdata),
      .end_of_stream (req_tlast),
      .nxt           (dec_next),
      .grp           (dec_grp)
   );

   // room for a whole group of results before taking a byte
   assign req_tready = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign push_count = req_xfer ? dec_grp.count : 3'd0;

   assign csr_ready = 1'b1;

   always_comb begin
      strict_in = (csr_valid && csr_ready) ? csr_data : strict_ff;
      state_in  = req_xfer ? dec_next : state_ff;
      tail_in   = tail_ff + PTR_W'(push_count);
      head_in   = rsp_xfer ? head_ff + PTR_W'(1) : head_ff;
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(rsp_xfer);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
         state_ff  <= STATE_RESET;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         strict_ff <= strict_in;
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   // queue write: up to four consecutive entries from the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (req_xfer && (3'(i) < dec_grp.count)) begin
            queue_mem[tail_ff + PTR_W'(i)]     <= dec_grp.res[i];
            queue_last_ff[tail_ff + PTR_W'(i)] <= (3'(i) == dec_grp.count - 3'd1);
         end
      end
   end

   assign rsp_tdata = {3'd0, queue_mem[head_ff].error_code, queue_mem[head_ff].out_byte};
   assign rsp_tuser = queue_mem[head_ff].kind;
   assign rsp_tlast = queue_last_ff[head_ff];

endmodule

// ===== tb/json_string_unescape_utf8_check_top_test.sv =====
// testbench for json_string_unescape_utf8_check_top: drives string body bytes, predicts
// decoded bytes, closes and errors, and checks every result transaction in order
// depends on jsu_pkg and the rtl of json_string_unescape_utf8_check_top
`timescale 1ns / 100ps

module json_string_unescape_utf8_check_top_test import jsu_pkg::*; ();

   // run limits
   localparam int unsigned CYCLE_LIMIT   = 100000;
   localparam int unsigned HOLD_CYCLES   = 150;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 10;
   localparam int unsigned PRINT_LIMIT   = 40;

   // characters with a special meaning in a string body
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LF     = 8'h0a;

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [4:0] error_code;
      logic       last;
   } decoded_type;

   // one req transaction: a body byte or the end of input
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } body_item_type;

   // decoder model plus the queue of results still owed by the block
   class string_decode_scoreboard;
      bit          strict_json;
      phase_type   phase;
      logic [2:0]  digits_left;
      logic [20:0] code_accum;
      logic [15:0] high_surrogate;
      logic [1:0]  utf8_extra;
      decoded_type expected_q[$];
      decoded_type step_q[$];
      int unsigned mismatches;

      function new();
         strict_json = 1'b1;
         mismatches  = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase          = PH_BODY;
         digits_left    = '0;
         code_accum     = '0;
         high_surrogate = '0;
         utf8_extra     = '0;
      endfunction

      function void add_result(logic [7:0] b, logic [1:0] kind, logic [4:0] code);
         decoded_type r;
         r.out_byte   = b;
         r.kind       = kind;
         r.error_code = code;
         r.last       = 1'b0;
         step_q.push_back(r);
      endfunction

      // error result, then back to a fresh string body
      function void flag_error(logic [4:0] code);
         add_result(8'h00, KIND_ERROR, code);
         clear_state();
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      // code point of a \u escape as 1 to 4 utf-8 bytes
      function void emit_utf8(int unsigned cp);
         if (cp < 'h80) begin
            add_result(cp, KIND_DATA, ERR_NONE);
         end else if (cp < 'h800) begin
            add_result('hc0 | (cp >> 6), KIND_DATA, ERR_NONE);
            add_result('h80 | (cp & 'h3f), KIND_DATA, ERR_NONE);
         end else if (cp < 'h10000) begin
            add_result('he0 | (cp >> 12), KIND_DATA, ERR_NONE);
            add_result('h80 | ((cp >> 6) & 'h3f), KIND_DATA, ERR_NONE);
            add_result('h80 | (cp & 'h3f), KIND_DATA, ERR_NONE);
         end else begin
            add_result('hf0 | ((cp >> 18) & 'h07), KIND_DATA, ERR_NONE);
            add_result('h80 | ((cp >> 12) & 'h3f), KIND_DATA, ERR_NONE);
            add_result('h80 | ((cp >> 6) & 'h3f), KIND_DATA, ERR_NONE);
            add_result('h80 | (cp & 'h3f), KIND_DATA, ERR_NONE);
         end
      endfunction

      // accepted req transaction: work out its results and queue them
      function void note_input(logic [7:0] c, logic eos);
         int          v;
         int unsigned minimum;
         int unsigned cp;
         step_q.delete();
         if (eos) begin
            flag_error(ERR_UNCLOSED);
         end else begin
            case (phase)
               PH_ESCAPE: begin
                  phase = PH_BODY;
                  case (c)
                     CH_LF: flag_error(ERR_NEWLINE);
                     CH_QUOTE, CH_BSLASH, "/": add_result(c, KIND_DATA, ERR_NONE);
                     "b": add_result(8'h08, KIND_DATA, ERR_NONE);
                     "f": add_result(8'h0c, KIND_DATA, ERR_NONE);
                     "n": add_result(8'h0a, KIND_DATA, ERR_NONE);
                     "r": add_result(8'h0d, KIND_DATA, ERR_NONE);
                     "t": add_result(8'h09, KIND_DATA, ERR_NONE);
                     "x": begin
                        if (strict_json) begin
                           flag_error(ERR_STRICT);
                        end else begin
                           phase       = PH_HEX;
                           digits_left = 3'd2;
                           code_accum  = '0;
                        end
                     end
                     "u": begin
                        phase       = PH_UNICODE;
                        digits_left = 3'd4;
                        code_accum  = '0;
                     end
                     default: begin
                        if (c >= "0" && c <= "7") begin
                           if (strict_json) begin
                              flag_error(ERR_STRICT);
                           end else begin
                              phase       = PH_OCTAL;
                              digits_left = 3'd2;
                              code_accum  = c - "0";
                           end
                        end else begin
                           flag_error(ERR_BAD_ESCAPE);
                        end
                     end
                  endcase
               end
               PH_HEX: begin
                  v = hex_value(c);
                  if (v < 0) begin
                     flag_error(ERR_HEX_DIGIT);
                  end else begin
                     code_accum  = ((code_accum << 4) | v) & 21'hff;
                     digits_left = digits_left - 3'd1;
                     if (digits_left == 0) begin
                        add_result(code_accum[7:0], KIND_DATA, ERR_NONE);
                        clear_state();
                     end
                  end
               end
               PH_OCTAL: begin
                  if (c < "0" || c > "7") begin
                     flag_error(ERR_OCT_DIGIT);
                  end else begin
                     code_accum  = ((code_accum << 3) | (c - "0")) & 21'h1ff;
                     digits_left = digits_left - 3'd1;
                     if (digits_left == 0) begin
                        if (code_accum > 'o377) begin
                           flag_error(ERR_OCT_RANGE);
                        end else begin
                           add_result(code_accum[7:0], KIND_DATA, ERR_NONE);
                           clear_state();
                        end
                     end
                  end
               end
               PH_UNICODE, PH_LOW_DIG: begin
                  v = hex_value(c);
                  if (v < 0) begin
                     flag_error(ERR_UNI_DIGIT);
                  end else begin
                     code_accum  = ((code_accum << 4) | v) & 21'hffff;
                     digits_left = digits_left - 3'd1;
                     if (digits_left == 0) begin
                        if (phase == PH_UNICODE) begin
                           if (code_accum >= 'hd800 && code_accum <= 'hdbff) begin
                              high_surrogate = code_accum[15:0];
                              phase          = PH_LOW_BSL;
                           end else if (code_accum >= 'hdc00 && code_accum <= 'hdfff) begin
                              flag_error(ERR_LONE_LOW);
                           end else begin
                              emit_utf8(code_accum);
                              clear_state();
                           end
                        end else if (code_accum < 'hdc00 || code_accum > 'hdfff) begin
                           flag_error(ERR_BAD_LOW);
                        end else begin
                           cp = 'h10000 + (((high_surrogate - 'hd800) & 'h3ff) << 10)
                                + (code_accum - 'hdc00);
                           emit_utf8(cp);
                           clear_state();
                        end
                     end
                  end
               end
               PH_LOW_BSL: begin
                  if (c != CH_BSLASH) flag_error(ERR_NO_LOW);
                  else phase = PH_LOW_U;
               end
               PH_LOW_U: begin
                  if (c != "u") begin
                     flag_error(ERR_NO_LOW);
                  end else begin
                     phase       = PH_LOW_DIG;
                     digits_left = 3'd4;
                     code_accum  = '0;
                  end
               end
               PH_UTF8: begin
                  if ((c & 8'hc0) != 8'h80) begin
                     flag_error(ERR_UTF8_SHORT);
                  end else begin
                     code_accum = (code_accum << 6) | (c & 8'h3f);
                     utf8_extra = utf8_extra - 2'd1;
                     if (utf8_extra != 0) begin
                        add_result(c, KIND_DATA, ERR_NONE);
                     end else begin
                        minimum = (digits_left == 1) ? 'h80 :
                                  (digits_left == 2) ? 'h800 : 'h10000;
                        if (code_accum < minimum) begin
                           flag_error(ERR_UTF8_OVERLONG);
                        end else if (code_accum >= 'hd800 && code_accum <= 'hdfff) begin
                           flag_error(ERR_UTF8_SURR);
                        end else if (code_accum > 'h10ffff) begin
                           flag_error(ERR_UTF8_RANGE);
                        end else begin
                           add_result(c, KIND_DATA, ERR_NONE);
                           clear_state();
                        end
                     end
                  end
               end
               default: begin
                  phase = PH_BODY;
                  if (c == CH_QUOTE) begin
                     add_result(8'h00, KIND_CLOSE, ERR_NONE);
                     clear_state();
                  end else if (c == CH_BSLASH) begin
                     phase = PH_ESCAPE;
                  end else if (c == CH_LF) begin
                     flag_error(ERR_NEWLINE);
                  end else if (c < 8'h20) begin
                     flag_error(ERR_CONTROL);
                  end else if (c < 8'h80) begin
                     add_result(c, KIND_DATA, ERR_NONE);
                  end else if ((c & 8'hc0) == 8'h80 || c >= 8'hf8) begin
                     flag_error(ERR_UTF8_LEAD);
                  end else begin
                     digits_left = (c >= 8'hf0) ? 3'd3 : (c >= 8'he0) ? 3'd2 : 3'd1;
                     code_accum  = c & ((digits_left == 1) ? 8'h1f :
                                        (digits_left == 2) ? 8'h0f : 8'h07);
                     utf8_extra  = digits_left[1:0];
                     phase       = PH_UTF8;
                     add_result(c, KIND_DATA, ERR_NONE);
                  end
               end
            endcase
         end
         if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      endtask

      // accepted rsp transaction against the oldest expectation
      task check_result(decoded_type got);
         decoded_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result byte %02h kind %0d code %0d last %0b",
                             got.out_byte, got.kind, got.error_code, got.last));
         end else begin
            want = expected_q.pop_front();
            if (got.kind != want.kind)
               report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.out_byte != want.out_byte)
               report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.error_code != want.error_code)
               report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
            if (got.last != want.last)
               report($sformatf("last %0b, want %0b", got.last, want.last));
         end
      endtask
   endclass

   // clock, reset and block inputs, all known from time zero
   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   string_decode_scoreboard sb = new();
   body_item_type plan[$];        // bytes still to be sent
   bit          steady     = 1'b0; // no idling on either side while set
   bit          hold_armed = 1'b0; // receiver starts a long hold-off when set
   int unsigned cycle_count = 0;

   json_string_unescape_utf8_check_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // hard stop if the run hangs
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request so the
   // result queue fills and req_tready drops
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
   end

   // result monitor: values sampled at the edge are the ones the block saw
   always @(posedge clock) begin
      decoded_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_byte   = rsp_tdata[7:0];
         got.error_code = rsp_tdata[12:8];
         got.kind       = rsp_tuser;
         got.last       = rsp_tlast;
         sb.check_result(got);
      end
   end

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   function automatic logic [7:0] hex_char(int unsigned v);
      if (v < 10) return "0" + v;
      return ($urandom_range(0, 1) ? "a" : "A") + v - 10;
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | $urandom_range(0, 63);
   endfunction

   function automatic void push_byte(logic [7:0] b);
      body_item_type it;
      it.data = b;
      it.eos  = 1'b0;
      plan.push_back(it);
   endfunction

   // end of input; the data byte is don't-care so it gets random bits
   function automatic void push_eos();
      body_item_type it;
      it.data = $urandom_range(0, 255);
      it.eos  = 1'b1;
      plan.push_back(it);
   endfunction

   function automatic void push_hex4(int unsigned v);
      for (int i = 3; i >= 0; i--) push_byte(hex_char((v >> (4 * i)) & 'hf));
   endfunction

   function automatic void push_u_escape(int unsigned v);
      push_byte(CH_BSLASH);
      push_byte("u");
      push_hex4(v);
   endfunction

   // well-formed piece of a string body with random content
   function automatic void add_clean_token();
      int unsigned r;
      int unsigned cp;
      case ($urandom_range(0, 6))
         0: begin
            repeat ($urandom_range(1, 3)) begin
               r = $urandom_range(8'h20, 8'h7e);
               if (r == CH_QUOTE || r == CH_BSLASH) r = "a";
               push_byte(r);
            end
         end
         1: begin
            push_byte(CH_BSLASH);
            case ($urandom_range(0, 7))
               0: push_byte(CH_QUOTE);
               1: push_byte(CH_BSLASH);
               2: push_byte("/");
               3: push_byte("b");
               4: push_byte("f");
               5: push_byte("n");
               6: push_byte("r");
               default: push_byte("t");
            endcase
         end
         2: begin
            // \u in the 1, 2 and 3 byte utf-8 ranges, never a surrogate
            case ($urandom_range(0, 2))
               0: cp = $urandom_range(0, 'h7f);
               1: cp = $urandom_range('h80, 'h7ff);
               default: cp = $urandom_range('h800, 'hffff);
            endcase
            if (cp >= 'hd800 && cp <= 'hdfff) cp ^= 'h8000;
            push_u_escape(cp);
         end
         3: begin
            // surrogate pair, gives a 4 byte sequence
            push_u_escape($urandom_range('hd800, 'hdbff));
            push_u_escape($urandom_range('hdc00, 'hdfff));
         end
         4: begin
            push_byte(CH_BSLASH);
            push_byte("x");
            push_byte(hex_char($urandom_range(0, 15)));
            push_byte(hex_char($urandom_range(0, 15)));
         end
         5: begin
            push_byte(CH_BSLASH);
            push_byte("0" + $urandom_range(0, 3));
            push_byte("0" + $urandom_range(0, 7));
            push_byte("0" + $urandom_range(0, 7));
         end
         default: begin
            // raw utf-8 passed through
            case ($urandom_range(0, 2))
               0: begin
                  cp = $urandom_range('h80, 'h7ff);
                  push_byte('hc0 | (cp >> 6));
                  push_byte('h80 | (cp & 'h3f));
               end
               1: begin
                  cp = $urandom_range('h800, 'hffff);
                  if (cp >= 'hd800 && cp <= 'hdfff) cp ^= 'h8000;
                  push_byte('he0 | (cp >> 12));
                  push_byte('h80 | ((cp >> 6) & 'h3f));
                  push_byte('h80 | (cp & 'h3f));
               end
               default: begin
                  cp = $urandom_range('h10000, 'h10ffff);
                  push_byte('hf0 | (cp >> 18));
                  push_byte('h80 | ((cp >> 12) & 'h3f));
                  push_byte('h80 | ((cp >> 6) & 'h3f));
                  push_byte('h80 | (cp & 'h3f));
               end
            endcase
         end
      endcase
   endfunction

   // broken piece: noise, bad escapes, bad surrogates, bad utf-8
   function automatic void add_broken_token();
      int unsigned k;
      case ($urandom_range(0, 8))
         0: push_byte($urandom_range(0, 255));
         1: begin
            push_byte(CH_BSLASH);
            push_byte($urandom_range(0, 255));
         end
         2: begin
            // \u with one random byte among the digits
            k = $urandom_range(0, 3);
            push_byte(CH_BSLASH);
            push_byte("u");
            for (int i = 0; i < 4; i++)
               push_byte((i == k) ? $urandom_range(0, 255) : hex_char($urandom_range(0, 15)));
         end
         3: push_u_escape($urandom_range('hdc00, 'hdfff));   // lone low surrogate
         4: begin
            // high surrogate with a bad or missing low half
            push_u_escape($urandom_range('hd800, 'hdbff));
            case ($urandom_range(0, 3))
               0: push_byte($urandom_range(0, 255));
               1: begin
                  push_byte(CH_BSLASH);
                  push_byte($urandom_range(0, 255));
               end
               2: push_u_escape($urandom_range(0, 'hd7ff));
               default: push_u_escape($urandom_range('hd800, 'hdbff));
            endcase
         end
         5: begin
            case ($urandom_range(0, 6))
               0: begin                             // overlong two byte form
                  push_byte(8'hc0 | $urandom_range(0, 1));
                  push_byte(cont_byte());
               end
               1: begin                             // overlong three byte form
                  push_byte(8'he0);
                  push_byte(8'h80 | $urandom_range(0, 31));
                  push_byte(cont_byte());
               end
               2: begin                             // overlong four byte form
                  push_byte(8'hf0);
                  push_byte(8'h80 | $urandom_range(0, 15));
                  push_byte(cont_byte());
                  push_byte(cont_byte());
               end
               3: begin                             // encoded surrogate
                  push_byte(8'hed);
                  push_byte(8'ha0 | $urandom_range(0, 31));
                  push_byte(cont_byte());
               end
               4: begin                             // above u+10ffff
                  if ($urandom_range(0, 1)) begin
                     push_byte(8'hf4);
                     push_byte($urandom_range(8'h90, 8'hbf));
                  end else begin
                     push_byte($urandom_range(8'hf5, 8'hf7));
                     push_byte(cont_byte());
                  end
                  push_byte(cont_byte());
                  push_byte(cont_byte());
               end
               5: begin                             // sequence cut short
                  push_byte($urandom_range(8'hc2, 8'hf4));
                  push_byte($urandom_range(0, 1) ? $urandom_range(0, 8'h7f)
                                                 : $urandom_range(8'hc0, 8'hff));
               end
               default: push_byte($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hbf)
                                                       : $urandom_range(8'hf8, 8'hff));
            endcase
         end
         6: begin
            push_byte(CH_BSLASH);
            if ($urandom_range(0, 1)) begin
               // octal value above 0377
               push_byte("4" + $urandom_range(0, 3));
               push_byte("0" + $urandom_range(0, 7));
               push_byte("0" + $urandom_range(0, 7));
            end else begin
               push_byte("0" + $urandom_range(0, 7));
               push_byte($urandom_range(0, 1) ? ("8" + $urandom_range(0, 1))
                                              : $urandom_range(0, 255));
            end
         end
         7: begin
            push_byte(CH_BSLASH);
            push_byte("x");
            push_byte(hex_char($urandom_range(0, 15)));
            push_byte($urandom_range(0, 1) ? "g" : $urandom_range(0, 255));
         end
         default: push_byte($urandom_range(0, 8'h1f));
      endcase
   endfunction

   // mostly well-formed strings, usually closed, sometimes cut by end of input
   function automatic void fill_random(int unsigned count);
      int unsigned r;
      while (plan.size() < count) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 99) < 85) add_clean_token();
            else add_broken_token();
         end
         r = $urandom_range(0, 99);
         if (r < 78) push_byte(CH_QUOTE);
         else if (r < 88) push_eos();
      end
   endfunction

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // one req transaction; valid stays high into the next byte unless an idle
   // gap is chosen, so it is never lowered and raised in the same step
   task automatic send_item(input logic [7:0] data, input logic eos);
      if (!steady) begin
         while ($urandom_range(0, 99) < 25) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      sb.note_input(data, eos);
   endtask

   task automatic run_plan();
      body_item_type it;
      while (plan.size() != 0) begin
         it = plan.pop_front();
         send_item(it.data, it.eos);
      end
   endtask

   // drop valid and wait until all owed results are in, then SETTLE_CYCLES more
   // since a byte with no result may still be in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_strict(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.strict_json = value;
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bytes, strict mode out of reset
      push_byte("a");                    // plain ascii
      push_byte(8'h00);                  // control byte, lowest value
      push_byte(CH_LF);                  // raw newline in the body
      push_byte(CH_BSLASH);              // newline right after a backslash
      push_byte(CH_LF);
      push_byte(8'hff);                  // bad utf-8 lead, highest value
      push_byte(8'he0);                  // overlong, fails on the last byte
      push_byte(8'h80);
      push_byte(8'h80);
      push_byte(CH_BSLASH);              // hex escape refused while strict
      push_byte("x");
      push_byte(CH_BSLASH);              // end of input in the middle of \u
      push_byte("u");
      push_eos();
      push_byte(CH_QUOTE);               // empty string closed
      push_eos();                        // end of input right after a close
      push_byte(8'h7f);                  // highest ascii passes through
      push_byte(8'hf4);                  // u+10ffff, the largest code point
      push_byte(8'h8f);
      push_byte(8'hbf);
      push_byte(8'hbf);
      push_byte(CH_BSLASH);
      push_byte("t");
      push_byte(CH_QUOTE);
      run_plan();
      settle();

      // relaxed mode: hex and octal escapes accepted
      write_strict(1'b0);
      fill_random(80);
      run_plan();
      settle();

      // strict mode, first a stretch with no idling on either side
      write_strict(1'b1);
      steady = 1'b1;
      fill_random(45);
      run_plan();
      steady = 1'b0;
      fill_random(45);
      run_plan();
      settle();

      // relaxed again with a long receiver hold-off while bytes keep coming
      write_strict(1'b0);
      hold_armed = 1'b1;
      fill_random(80);
      run_plan();

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
